// File: hw/rtl/qpht_pkg.sv
`timescale 1ns / 1ps
package qpht_pkg;

    // table geometry; probing and hash folding rely on the slot count being a power of two
    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int HALF_SLOTS  = TABLE_SLOTS / 2;
    localparam int KEY_CHARS   = 8;
    localparam int KEY_W       = 64;
    localparam int HANDLE_W    = 16;
    localparam int HASH_W      = 16;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

    localparam logic [HASH_W-1:0] CHAR_BASE = 16'd97;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [SLOT_W-1:0]   hash;
    } t_job;

    typedef struct packed {
        logic                used;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_slot;

    localparam int SLOT_WORD_W = $bits(t_slot);

    typedef struct packed {
        logic init_busy;
    } t_back_stat;

    // drop bytes after the first zero byte and beyond KEY_CHARS
    function automatic logic [KEY_W-1:0] f_normalize(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] k;
        logic             live;
        k    = '0;
        live = 1'b1;
        for (int n = 0; n < KEY_CHARS; n++) begin
            if (raw[8*n +: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                k[8*n +: 8] = raw[8*n +: 8];
            end
        end
        return k;
    endfunction

    function automatic logic [SLOT_W-1:0] f_hash(input logic [KEY_W-1:0] k);
        logic [HASH_W-1:0] h;
        logic              live;
        h    = '0;
        live = 1'b1;
        for (int n = 0; n < 8; n++) begin
            if (k[8*n +: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                h = (h << 5) ^ ({8'd0, k[8*n +: 8]} - CHAR_BASE);
            end
        end
        return h[SLOT_W-1:0];
    endfunction

endpackage

// File: hw/rtl/quadratic_probe_hash_table.sv
`timescale 1ns / 1ps
// open-addressed symbol table with quadratic probing over 1024 slots held in one
// single-port-read slot ram; the front normalises the key and hashes it in the
// accepting cycle and drops the job into a two-entry queue, the back end runs it.
// an insert or lookup reads one slot per probe visited (one slot ram read per
// cycle); a clear sweeps every slot. after reset the same clearing pass runs
// and no transaction is taken on the input side until it ends. results sit in
// an output register, so the queue keeps filling while a result is stalled
module quadratic_probe_hash_table
    import qpht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input transactions
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [KEY_W-1:0]    i_symbol_key,
    input  logic [HANDLE_W-1:0] i_entry_handle,
    // result transactions
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_found_handle,
    output logic [SLOT_W-1:0]   o_slot_index
);

    t_job       w_push_job;
    t_job       w_pop_job;
    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_empty;
    t_back_stat w_stat;

    // front: normalise, hash, queue
    qpht_front u_front (
        .i_valid        (i_in_valid),
        .i_command      (i_command),
        .i_symbol_key   (i_symbol_key),
        .i_entry_handle (i_entry_handle),
        .i_full         (w_full),
        .i_stat         (w_stat),
        .o_stall        (o_in_stall),
        .o_push         (w_push),
        .o_job          (w_push_job)
    );

    // decoupling queue between the two halves
    qpht_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // back: probe sequencer, slot ram, clearing sweep, result register
    qpht_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_job          (w_pop_job),
        .o_pop          (w_pop),
        .o_stat         (w_stat),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_found_handle (o_found_handle),
        .o_slot_index   (o_slot_index)
    );

    // queue never overflows or underflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!w_full || w_pop))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job popped from an empty queue");

    // nothing taken in while the start-up sweep runs
    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.init_busy |-> (!w_push && !o_out_valid))
        else $error("activity during start-up clearing pass");

    // handle only reported with a hit
    a_handle_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_FOUND) |-> (o_found_handle == '0))
        else $error("handle reported without a match");

endmodule

// File: hw/rtl/qpht_ram.sv
`timescale 1ns / 1ps
module qpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/qpht_fifo.sv
`timescale 1ns / 1ps
module qpht_fifo
    import qpht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job                  r_buf [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp, n_wp;
    logic [FIFO_PTR_W-1:0] r_rp, n_rp;
    logic [FIFO_CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_buf[r_wp] <= i_job;
        end
    end

    assign o_job   = r_buf[r_rp];
    assign o_full  = (r_cnt == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

// File: hw/rtl/qpht_front.sv
`timescale 1ns / 1ps
module qpht_front
    import qpht_pkg::*;
(
    input  logic                i_valid,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [KEY_W-1:0]    i_symbol_key,
    input  logic [HANDLE_W-1:0] i_entry_handle,
    input  logic                i_full,
    input  t_back_stat          i_stat,
    output logic                o_stall,
    output logic                o_push,
    output t_job                o_job
);

    logic [KEY_W-1:0] w_key;

    assign w_key   = f_normalize(i_symbol_key);
    assign o_stall = i_full | i_stat.init_busy;
    assign o_push  = i_valid & ~o_stall;

    always_comb begin
        o_job.cmd    = i_command;
        o_job.key    = w_key;
        o_job.handle = i_entry_handle;
        o_job.hash   = f_hash(w_key);
    end

endmodule

// File: hw/rtl/qpht_back.sv
`timescale 1ns / 1ps
module qpht_back
    import qpht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  t_job                i_job,
    output logic                o_pop,
    output t_back_stat          o_stat,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_found_handle,
    output logic [SLOT_W-1:0]   o_slot_index
);

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

    logic [1:0]          r_state, n_state;
    logic [SLOT_W-1:0]   r_clr_cnt, n_clr_cnt;
    logic                r_clr_reply, n_clr_reply;
    logic                r_clr_init, n_clr_init;
    t_job                r_job, n_job;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [SLOT_W-1:0]   r_i, n_i;
    logic [SLOT_W-1:0]   r_sq, n_sq;
    logic [SLOT_W-1:0]   r_count, n_count;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [HANDLE_W-1:0] r_found, n_found;
    logic [SLOT_W-1:0]   r_sidx, n_sidx;

    logic                  w_we;
    logic [SLOT_W-1:0]     w_waddr;
    t_slot                 w_wdata;
    logic [SLOT_W-1:0]     w_raddr;
    logic [SLOT_WORD_W-1:0] w_rdata;
    t_slot                 w_rd;
    logic                  w_out_free;
    logic [SLOT_W-1:0]     w_nsq;
    logic [SLOT_W:0]       w_step;

    qpht_ram #(
        .WIDTH (SLOT_WORD_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd       = t_slot'(w_rdata);
    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_step     = {r_i, 1'b1};
    assign w_nsq      = r_sq + w_step[SLOT_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_clr_reply = r_clr_reply;
        n_clr_init  = r_clr_init;
        n_job       = r_job;
        n_slot      = r_slot;
        n_i         = r_i;
        n_sq        = r_sq;
        n_count     = r_count;
        n_out_valid = r_out_valid & i_out_stall;
        n_status    = r_status;
        n_found     = r_found;
        n_sidx      = r_sidx;
        w_we        = 1'b0;
        w_waddr     = r_slot;
        w_wdata     = '0;
        w_raddr     = r_slot;
        o_pop       = 1'b0;

        unique case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_cnt;
                if (r_clr_cnt == SLOT_LAST) begin
                    n_count    = '0;
                    n_state    = S_IDLE;
                    n_clr_init = 1'b0;
                    if (r_clr_reply) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_CLEARED;
                        n_found     = '0;
                        n_sidx      = '0;
                    end
                end else begin
                    n_clr_cnt = r_clr_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (!i_empty && w_out_free) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    unique case (i_job.cmd) inside
                        CMD_CLEAR: begin
                            n_state     = S_CLR;
                            n_clr_cnt   = '0;
                            n_clr_reply = 1'b1;
                        end
                        CMD_INSERT, CMD_LOOKUP: begin
                            w_raddr = i_job.hash;
                            n_slot  = i_job.hash;
                            n_i     = '0;
                            n_sq    = '0;
                            n_state = S_CHK;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_status    = ST_ABSENT;
                            n_found     = '0;
                            n_sidx      = '0;
                        end
                    endcase
                end
            end
            S_CHK: begin
                if (r_job.cmd == CMD_INSERT) begin
                    if (!w_rd.used) begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b1;
                        n_found     = '0;
                        if (r_count >= SLOT_W'(HALF_SLOTS - 1)) begin
                            n_status = ST_REFUSED;
                            n_sidx   = '0;
                        end else begin
                            w_we           = 1'b1;
                            w_waddr        = r_slot;
                            w_wdata.used   = 1'b1;
                            w_wdata.key    = r_job.key;
                            w_wdata.handle = r_job.handle;
                            n_count        = r_count + 1'b1;
                            n_status       = ST_INSERTED;
                            n_sidx         = r_slot;
                        end
                    end else if (r_i == SLOT_LAST) begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b1;
                        n_status    = ST_NO_SLOT;
                        n_found     = '0;
                        n_sidx      = '0;
                    end else begin
                        w_raddr = r_job.hash + w_nsq;
                        n_slot  = r_job.hash + w_nsq;
                        n_i     = r_i + 1'b1;
                        n_sq    = w_nsq;
                    end
                end else begin
                    if (w_rd.used && w_rd.key == r_job.key) begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b1;
                        n_status    = ST_FOUND;
                        n_found     = w_rd.handle;
                        n_sidx      = r_slot;
                    end else if (!w_rd.used || r_i == SLOT_LAST) begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b1;
                        n_status    = ST_ABSENT;
                        n_found     = '0;
                        n_sidx      = '0;
                    end else begin
                        w_raddr = r_job.hash + w_nsq;
                        n_slot  = r_job.hash + w_nsq;
                        n_i     = r_i + 1'b1;
                        n_sq    = w_nsq;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_cnt   <= '0;
            r_clr_reply <= 1'b0;
            r_clr_init  <= 1'b1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_clr_reply <= n_clr_reply;
            r_clr_init  <= n_clr_init;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_job    <= n_job;
        r_slot   <= n_slot;
        r_i      <= n_i;
        r_sq     <= n_sq;
        r_status <= n_status;
        r_found  <= n_found;
        r_sidx   <= n_sidx;
    end

    assign o_stat.init_busy = r_clr_init;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_found_handle   = r_found;
    assign o_slot_index     = r_sidx;

endmodule
